### hw/rtl/midi_note_event_pairer_top_defines.svh
// ============================================================================
// midi_note_event_pairer_top_defines.svh
// Assertion macros shared by the checker of the note event pairer.
// ============================================================================
`ifndef MIDI_NOTE_EVENT_PAIRER_TOP_DEFINES_SVH
`define MIDI_NOTE_EVENT_PAIRER_TOP_DEFINES_SVH

// check a property at every clock edge outside reset
`define MNEP_ASSERT_SYNC(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// check a property at every clock edge, reset included
`define MNEP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

### hw/rtl/mnep_pkg.sv
// ============================================================================
// mnep_pkg
// Types, codes and helpers of the MIDI note event pairer.
// ============================================================================
package mnep_pkg;

    localparam int NUM_KEYS = 128;
    localparam int KEY_W    = $clog2(NUM_KEYS);
    localparam int TICK_W   = 32;
    localparam int ENTRY_W  = TICK_W + 8;

    localparam logic [7:0] CMD_NOTE_OFF = 8'h80;
    localparam logic [7:0] CMD_NOTE_ON  = 8'h90;
    localparam logic [7:0] CMD_CTRL     = 8'hB0;
    localparam logic [7:0] CMD_PROG     = 8'hC0;
    localparam logic [7:0] CMD_SYS      = 8'hF0;
    localparam logic [7:0] CMD_META     = 8'hFF;
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] META_METER   = 8'h58;
    localparam logic [7:0] META_KEYSIG  = 8'h59;
    localparam logic [7:0] NIBBLE_MASK  = 8'h0F;

    typedef enum logic [2:0] {
        KIND_NOTE,
        KIND_CTRL,
        KIND_INSTR,
        KIND_TEMPO,
        KIND_METER,
        KIND_KEYSIG
    } t_kind;

    typedef struct packed {
        logic [7:0]        track_number;
        logic [TICK_W-1:0] event_tick;
        logic [7:0]        byte_five;
        logic [7:0]        byte_four;
        logic [7:0]        byte_three;
        logic [7:0]        byte_two;
        logic [7:0]        byte_one;
        logic [7:0]        status;
    } t_event;

    typedef struct packed {
        logic              hit;
        logic [7:0]        velocity;
        logic [TICK_W-1:0] start;
    } t_lookup;

    typedef struct packed {
        logic [2:0]        pad;
        logic              start_unknown;
        logic [7:0]        track;
        logic [3:0]        channel;
        logic [7:0]        accidentals;
        logic [15:0]       amount;
        logic [23:0]       number;
        logic [TICK_W-1:0] duration;
        logic [TICK_W-1:0] start_time;
    } t_record;

    function automatic logic [7:0] command(input logic [7:0] status);
        logic [7:0] cmd;
        cmd = status & ~NIBBLE_MASK;
        if (cmd == CMD_SYS) begin
            cmd = status;
        end
        return cmd;
    endfunction

    function automatic logic key_in_range(input logic [7:0] key);
        return {1'b0, key} < 9'(NUM_KEYS);
    endfunction

endpackage

### hw/rtl/mnep_ram.sv
// ============================================================================
// mnep_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module mnep_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/mnep_table.sv
// ============================================================================
// mnep_table
// Per-key note-on table: start tick and velocity in RAM, seen bits in flops.
// ============================================================================
module mnep_table
    import mnep_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_lookup_en,
    input  logic              i_write_en,
    input  logic [7:0]        i_key,
    input  logic [TICK_W-1:0] i_tick,
    input  logic [7:0]        i_velocity,
    output t_lookup           o_lookup
);

    logic [NUM_KEYS-1:0] r_seen;
    logic                r_hit;
    logic [KEY_W-1:0]    w_idx;
    logic [ENTRY_W-1:0]  w_rd_data;

    assign w_idx = i_key[KEY_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_hit  <= 1'b0;
        end else begin
            if (i_write_en) begin
                r_seen[w_idx] <= 1'b1;
            end
            if (i_lookup_en) begin
                r_hit <= key_in_range(i_key) && r_seen[w_idx];
            end
        end
    end

    mnep_ram #(
        .DEPTH (NUM_KEYS),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_write_en),
        .i_wr_addr (w_idx),
        .i_wr_data ({i_velocity, i_tick}),
        .i_rd_en   (i_lookup_en),
        .i_rd_addr (w_idx),
        .o_rd_data (w_rd_data)
    );

    assign o_lookup.hit      = r_hit;
    assign o_lookup.velocity = w_rd_data[ENTRY_W-1:TICK_W];
    assign o_lookup.start    = w_rd_data[TICK_W-1:0];

endmodule

### hw/rtl/mnep_format.sv
// ============================================================================
// mnep_format
// Builds the result record from an event and its table lookup, output register.
// ============================================================================
module mnep_format
    import mnep_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_event        i_event,
    input  t_lookup       i_lookup,
    output logic          o_take,
    output logic          o_valid,
    input  logic          i_ready,
    output t_record       o_record,
    output t_kind         o_kind
);

    logic    r_out_valid;
    t_record r_record;
    t_kind   r_kind;
    logic    w_take;
    logic    w_emit;
    t_record w_rec;
    t_kind   w_kind;

    assign w_take = !r_out_valid || i_ready;

    always_comb begin
        logic [7:0] cmd;
        logic [3:0] chan;
        cmd    = command(i_event.status);
        chan   = 4'(i_event.status & NIBBLE_MASK);
        w_rec  = '0;
        w_kind = KIND_NOTE;
        w_emit = 1'b0;
        w_rec.track = i_event.track_number;
        if (cmd == CMD_NOTE_ON && i_event.byte_two != 8'd0) begin
            w_emit = 1'b0;
        end else if (cmd == CMD_NOTE_ON || cmd == CMD_NOTE_OFF) begin
            w_emit         = 1'b1;
            w_rec.number   = 24'(i_event.byte_one);
            w_rec.channel  = chan;
            if (i_lookup.hit) begin
                w_rec.start_time = i_lookup.start;
                w_rec.duration   = i_event.event_tick - i_lookup.start;
                w_rec.amount     = 16'(i_lookup.velocity);
            end else begin
                w_rec.start_unknown = 1'b1;
            end
        end else if (cmd == CMD_CTRL) begin
            w_emit           = 1'b1;
            w_kind           = KIND_CTRL;
            w_rec.start_time = i_event.event_tick;
            w_rec.number     = 24'(i_event.byte_one);
            w_rec.amount     = 16'(i_event.byte_two);
            w_rec.channel    = chan;
        end else if (cmd == CMD_PROG) begin
            w_emit           = 1'b1;
            w_kind           = KIND_INSTR;
            w_rec.start_time = i_event.event_tick;
            w_rec.number     = 24'(i_event.byte_one);
            w_rec.channel    = chan;
        end else if (cmd == CMD_META) begin
            w_rec.start_time = i_event.event_tick;
            if (i_event.byte_one == META_TEMPO) begin
                w_emit       = 1'b1;
                w_kind       = KIND_TEMPO;
                w_rec.number = {i_event.byte_three, i_event.byte_four, i_event.byte_five};
            end else if (i_event.byte_one == META_METER) begin
                w_emit       = 1'b1;
                w_kind       = KIND_METER;
                w_rec.number = 24'(i_event.byte_three);
                if (i_event.byte_four > 8'd15) begin
                    w_rec.amount = 16'h8000;
                end else begin
                    w_rec.amount = 16'd1 << i_event.byte_four[3:0];
                end
            end else if (i_event.byte_one == META_KEYSIG) begin
                w_emit            = 1'b1;
                w_kind            = KIND_KEYSIG;
                w_rec.amount      = 16'(i_event.byte_four);
                w_rec.accidentals = i_event.byte_three;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= i_valid && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_valid && w_emit) begin
            r_record <= w_rec;
            r_kind   <= w_kind;
        end
    end

    assign o_take   = w_take;
    assign o_valid  = r_out_valid;
    assign o_record = r_record;
    assign o_kind   = r_kind;

endmodule

### hw/rtl/midi_note_event_pairer_top.sv
// An accepted item is registered in the first stage, its record in the output
// stage. Throughput: 1 item per cycle unless the master side stalls; each item
// reads the key table RAM at the cycle of acceptance, and a stored note-on also
// writes its entry in that same cycle. Items that make no record are dropped in
// the second stage. Reset clears the pipeline valids and all note-seen bits;
// the table RAM holds no reset, and its data is used only for keys marked seen.
// ============================================================================
// midi_note_event_pairer_top
// Pairs MIDI note-on and note-off events into note records per key.
// ============================================================================
module midi_note_event_pairer_top
    import mnep_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // status, byte_one, byte_two, byte_three, byte_four, byte_five,
    // event_tick, track_number
    input  logic [87:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // start_time, duration, number, amount, accidentals, channel, track,
    // start_unknown, zero fill
    output logic [127:0] m_axis_tdata,
    // kind
    output logic [2:0]   m_axis_tuser
);

    t_event  w_event;
    logic    w_accept;
    logic    w_write;
    logic    w_take;
    logic    r_s1_valid;
    t_event  r_s1_event;
    t_lookup w_lookup;
    t_record w_record;
    t_kind   w_kind;

    assign w_event       = t_event'(s_axis_tdata);
    assign s_axis_tready = !r_s1_valid || w_take;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_write       = w_accept && command(w_event.status) == CMD_NOTE_ON
                           && w_event.byte_two != 8'd0 && key_in_range(w_event.byte_one);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_event <= w_event;
        end
    end

    mnep_table u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lookup_en (w_accept),
        .i_write_en  (w_write),
        .i_key       (w_event.byte_one),
        .i_tick      (w_event.event_tick),
        .i_velocity  (w_event.byte_two),
        .o_lookup    (w_lookup)
    );

    mnep_format u_format (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s1_valid),
        .i_event  (r_s1_event),
        .i_lookup (w_lookup),
        .o_take   (w_take),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_record (w_record),
        .o_kind   (w_kind)
    );

    assign m_axis_tdata = w_record;
    assign m_axis_tuser = w_kind;

endmodule

### hw/rtl/mnep_checker.sv
// ============================================================================
// mnep_checker
// Port-level checks of the note event pairer, bound to the top level.
// ============================================================================
`include "midi_note_event_pairer_top_defines.svh"

module mnep_checker
    import mnep_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [2:0]   m_axis_tuser
);

    `MNEP_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !m_axis_tvalid,
        "output valid after reset")

    `MNEP_ASSERT_SYNC(a_stall_hold, m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "stalled item changed")

    `MNEP_ASSERT_SYNC(a_kind_range, m_axis_tvalid |-> m_axis_tuser <= 3'(KIND_KEYSIG),
        "kind out of range")

    `MNEP_ASSERT_SYNC(a_unknown_zero,
        m_axis_tvalid && m_axis_tuser == 3'(KIND_NOTE) && m_axis_tdata[124] |->
        m_axis_tdata[63:0] == 64'd0 && m_axis_tdata[103:88] == 16'd0,
        "unmatched note-off carries data")

    `MNEP_ASSERT_SYNC(a_other_kinds, m_axis_tvalid && m_axis_tuser != 3'(KIND_NOTE) |->
        m_axis_tdata[63:32] == 32'd0 && !m_axis_tdata[124],
        "non-note record has duration")

endmodule

bind midi_note_event_pairer_top mnep_checker u_mnep_checker (.*);

### test/tb.sv
// ============================================================================
// tb
// Self-checking testbench of the MIDI note event pairer. A short table of
// directed events covers the extreme keys, ticks and meta values, then
// random, mostly well-formed note, control, program and meta traffic runs
// with bursty input and a stalling output. Every record is compared field
// by field against a row's record or a per-key note model's prediction.
// ============================================================================
module tb;
    import mnep_pkg::*;

    localparam int ITEM_GOAL   = 570;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_GUARD = 5000;
    localparam int TAIL_CYCLES = 10;

    localparam logic [7:0] CMD_AFTERTOUCH = 8'hA0;
    localparam logic [7:0] CMD_PITCH      = 8'hE0;
    localparam logic [7:0] SYS_CLOCK      = 8'hF8;
    localparam logic [7:0] META_END       = 8'h2F;

    typedef enum {ROW_PREDICT, ROW_NONE, ROW_RECORD} t_row_mode;

    typedef struct packed {
        t_kind   kind;
        t_record rec;
    } t_note_rec;

    typedef struct {
        t_event    ev;
        t_row_mode mode;
        t_note_rec want;
    } t_stim_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // status, byte_one, byte_two, byte_three, byte_four, byte_five,
    // event_tick, track_number
    logic [87:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // start_time, duration, number, amount, accidentals, channel, track,
    // start_unknown, zero fill
    logic [127:0] m_axis_tdata;
    // kind
    logic [2:0]   m_axis_tuser;

    logic [31:0]  key_start    [0:NUM_KEYS-1];
    logic [7:0]   key_velocity [0:NUM_KEYS-1];
    bit           key_seen     [0:NUM_KEYS-1];

    t_note_rec    pending_records[$];
    t_stim_row    directed_rows[$];
    logic [31:0]  tick_now;
    int           error_count;
    bit           hold_request;

    midi_note_event_pairer_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("[midi_note_event_pairer_top] ERROR");
        $finish;
    end

    function automatic t_event mk_event(input logic [7:0] status, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3,
                                        input logic [7:0] b4, input logic [7:0] b5,
                                        input logic [31:0] tick, input logic [7:0] trk);
        t_event ev;
        ev.status       = status;
        ev.byte_one     = b1;
        ev.byte_two     = b2;
        ev.byte_three   = b3;
        ev.byte_four    = b4;
        ev.byte_five    = b5;
        ev.event_tick   = tick;
        ev.track_number = trk;
        return ev;
    endfunction

    function automatic t_note_rec mk_rec(input t_kind kind, input logic [31:0] start,
                                         input logic [31:0] dur, input logic [23:0] num,
                                         input logic [15:0] amt, input logic [7:0] acc,
                                         input logic [3:0] ch, input logic [7:0] trk,
                                         input logic unk);
        t_note_rec r;
        r = '0;
        r.kind              = kind;
        r.rec.start_time    = start;
        r.rec.duration      = dur;
        r.rec.number        = num;
        r.rec.amount        = amt;
        r.rec.accidentals   = acc;
        r.rec.channel       = ch;
        r.rec.track         = trk;
        r.rec.start_unknown = unk;
        return r;
    endfunction

    task automatic pair_note_event(input t_event ev, output bit has_rec, output t_note_rec r);
        logic [7:0]       cmd;
        logic [3:0]       chan;
        logic [KEY_W-1:0] idx;
        cmd  = ev.status & ~NIBBLE_MASK;
        chan = ev.status[3:0];
        idx  = ev.byte_one[KEY_W-1:0];
        if (cmd == CMD_SYS) begin
            cmd = ev.status;
        end
        has_rec          = 1'b0;
        r                = '0;
        r.rec.track      = ev.track_number;
        r.rec.start_time = ev.event_tick;
        if (cmd == CMD_NOTE_ON && ev.byte_two != 8'd0) begin
            if (ev.byte_one < NUM_KEYS) begin
                key_start[idx]    = ev.event_tick;
                key_velocity[idx] = ev.byte_two;
                key_seen[idx]     = 1'b1;
            end
        end else if (cmd == CMD_NOTE_ON || cmd == CMD_NOTE_OFF) begin
            has_rec         = 1'b1;
            r.kind          = KIND_NOTE;
            r.rec.number    = 24'(ev.byte_one);
            r.rec.channel   = chan;
            if (ev.byte_one < NUM_KEYS && key_seen[idx]) begin
                r.rec.start_time = key_start[idx];
                r.rec.duration   = ev.event_tick - key_start[idx];
                r.rec.amount     = 16'(key_velocity[idx]);
            end else begin
                r.rec.start_time    = '0;
                r.rec.start_unknown = 1'b1;
            end
        end else if (cmd == CMD_CTRL) begin
            has_rec       = 1'b1;
            r.kind        = KIND_CTRL;
            r.rec.number  = 24'(ev.byte_one);
            r.rec.amount  = 16'(ev.byte_two);
            r.rec.channel = chan;
        end else if (cmd == CMD_PROG) begin
            has_rec       = 1'b1;
            r.kind        = KIND_INSTR;
            r.rec.number  = 24'(ev.byte_one);
            r.rec.channel = chan;
        end else if (cmd == CMD_META) begin
            case (ev.byte_one)
                META_TEMPO: begin
                    has_rec      = 1'b1;
                    r.kind       = KIND_TEMPO;
                    r.rec.number = {ev.byte_three, ev.byte_four, ev.byte_five};
                end
                META_METER: begin
                    has_rec      = 1'b1;
                    r.kind       = KIND_METER;
                    r.rec.number = 24'(ev.byte_three);
                    r.rec.amount = (ev.byte_four > 8'd15) ? 16'h8000
                                                          : (16'd1 << ev.byte_four);
                end
                META_KEYSIG: begin
                    has_rec           = 1'b1;
                    r.kind            = KIND_KEYSIG;
                    r.rec.amount      = 16'(ev.byte_four);
                    r.rec.accidentals = ev.byte_three;
                end
                default: begin
                end
            endcase
        end
    endtask

    function automatic t_event next_random_event(output bit ignorable);
        t_event     ev;
        int         pick;
        logic [7:0] key;
        logic [7:0] ch;
        ev = mk_event(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      32'd0, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 19) == 0) begin
            tick_now = $urandom;
        end else begin
            tick_now = tick_now + 32'($urandom_range(0, 500));
        end
        ev.event_tick = tick_now;
        key = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 11));
        ch        = 8'($urandom_range(0, 15));
        ignorable = 1'b0;
        pick      = $urandom_range(0, 99);
        if (pick < 35) begin
            ev.status   = CMD_NOTE_ON | ch;
            ev.byte_one = key;
            ev.byte_two = 8'($urandom_range(1, 255));
        end else if (pick < 60) begin
            ev.byte_one = key;
            if ($urandom_range(0, 1) == 0) begin
                ev.status = CMD_NOTE_OFF | ch;
            end else begin
                ev.status   = CMD_NOTE_ON | ch;
                ev.byte_two = 8'd0;
            end
        end else if (pick < 68) begin
            ev.status = CMD_CTRL | ch;
        end else if (pick < 74) begin
            ev.status = CMD_PROG | ch;
        end else if (pick < 80) begin
            ev.status   = CMD_META;
            ev.byte_one = META_TEMPO;
        end else if (pick < 86) begin
            ev.status   = CMD_META;
            ev.byte_one = META_METER;
            if ($urandom_range(0, 3) != 0) begin
                ev.byte_four = 8'($urandom_range(0, 20));
            end
        end else if (pick < 91) begin
            ev.status   = CMD_META;
            ev.byte_one = META_KEYSIG;
        end else if (pick < 95) begin
            ev.status = CMD_META;
            ignorable = 1'b1;
        end else begin
            ignorable = 1'b1;
        end
        return ev;
    endfunction

    task automatic add_row(input t_event ev, input t_row_mode mode, input t_note_rec want);
        t_stim_row row;
        row.ev   = ev;
        row.mode = mode;
        row.want = want;
        directed_rows = {directed_rows, row};
    endtask

    task automatic build_directed_rows();
        add_row(mk_event(CMD_NOTE_OFF, 60, 0, 0, 0, 0, 100, 1), ROW_RECORD,
                mk_rec(KIND_NOTE, 0, 0, 60, 0, 0, 0, 1, 1));
        add_row(mk_event(CMD_NOTE_ON | 8'h03, 60, 127, 0, 0, 0, 200, 2), ROW_NONE, '0);
        add_row(mk_event(CMD_NOTE_ON | 8'h03, 60, 0, 0, 0, 0, 350, 2), ROW_RECORD,
                mk_rec(KIND_NOTE, 200, 150, 60, 127, 0, 3, 2, 0));
        add_row(mk_event(CMD_NOTE_ON | 8'h0F, 0, 1, 0, 0, 0, 0, 0), ROW_NONE, '0);
        add_row(mk_event(CMD_NOTE_OFF | 8'h0F, 0, 8'h40, 0, 0, 0, 32'hFFFF_FFFF, 255),
                ROW_RECORD, mk_rec(KIND_NOTE, 0, 32'hFFFF_FFFF, 0, 1, 0, 15, 255, 0));
        add_row(mk_event(CMD_NOTE_ON, 127, 255, 0, 0, 0, 32'hFFFF_FFF0, 7), ROW_NONE, '0);
        add_row(mk_event(CMD_NOTE_OFF, 127, 0, 0, 0, 0, 32'h10, 7), ROW_RECORD,
                mk_rec(KIND_NOTE, 32'hFFFF_FFF0, 32'h20, 127, 255, 0, 0, 7, 0));
        add_row(mk_event(CMD_NOTE_ON, 128, 10, 0, 0, 0, 5, 0), ROW_NONE, '0);
        add_row(mk_event(CMD_NOTE_OFF, 128, 0, 0, 0, 0, 6, 0), ROW_RECORD,
                mk_rec(KIND_NOTE, 0, 0, 128, 0, 0, 0, 0, 1));
        add_row(mk_event(CMD_NOTE_ON, 255, 0, 0, 0, 0, 7, 0), ROW_RECORD,
                mk_rec(KIND_NOTE, 0, 0, 255, 0, 0, 0, 0, 1));
        add_row(mk_event(CMD_NOTE_OFF | 8'h01, 60, 0, 0, 0, 0, 400, 9), ROW_PREDICT, '0);
        add_row(mk_event(CMD_CTRL | 8'h05, 7, 100, 0, 0, 0, 1000, 3), ROW_RECORD,
                mk_rec(KIND_CTRL, 1000, 0, 7, 100, 0, 5, 3, 0));
        add_row(mk_event(CMD_CTRL | 8'h0F, 255, 255, 255, 255, 255, 32'hFFFF_FFFF, 255),
                ROW_PREDICT, '0);
        add_row(mk_event(CMD_PROG | 8'h02, 42, 99, 0, 0, 0, 2000, 4), ROW_RECORD,
                mk_rec(KIND_INSTR, 2000, 0, 42, 0, 0, 2, 4, 0));
        add_row(mk_event(CMD_META, META_TEMPO, 3, 8'h07, 8'hA1, 8'h20, 0, 0), ROW_RECORD,
                mk_rec(KIND_TEMPO, 0, 0, 24'h07A120, 0, 0, 0, 0, 0));
        add_row(mk_event(CMD_META, META_TEMPO, 3, 255, 255, 255, 3000, 5), ROW_PREDICT, '0);
        add_row(mk_event(CMD_META, META_METER, 4, 4, 2, 24, 4000, 1), ROW_RECORD,
                mk_rec(KIND_METER, 4000, 0, 4, 4, 0, 0, 1, 0));
        add_row(mk_event(CMD_META, META_METER, 4, 255, 15, 8, 4001, 1), ROW_RECORD,
                mk_rec(KIND_METER, 4001, 0, 255, 16'h8000, 0, 0, 1, 0));
        add_row(mk_event(CMD_META, META_METER, 4, 3, 16, 8, 4002, 1), ROW_RECORD,
                mk_rec(KIND_METER, 4002, 0, 3, 16'h8000, 0, 0, 1, 0));
        add_row(mk_event(CMD_META, META_METER, 4, 2, 255, 0, 4003, 1), ROW_PREDICT, '0);
        add_row(mk_event(CMD_META, META_KEYSIG, 2, 8'hFD, 1, 0, 5000, 2), ROW_RECORD,
                mk_rec(KIND_KEYSIG, 5000, 0, 0, 1, 8'hFD, 0, 2, 0));
        add_row(mk_event(CMD_META, META_KEYSIG, 2, 8'h7F, 255, 0, 5001, 2), ROW_PREDICT, '0);
        add_row(mk_event(CMD_META, META_END, 0, 0, 0, 0, 6000, 0), ROW_NONE, '0);
        add_row(mk_event(CMD_SYS, META_TEMPO, 3, 1, 2, 3, 6001, 0), ROW_NONE, '0);
        add_row(mk_event(SYS_CLOCK, META_METER, 4, 1, 2, 3, 6002, 0), ROW_NONE, '0);
        add_row(mk_event(CMD_AFTERTOUCH | 8'h03, 60, 50, 0, 0, 0, 6003, 0), ROW_NONE, '0);
        add_row(mk_event(CMD_PITCH | 8'h03, 0, 64, 0, 0, 0, 6004, 0), ROW_NONE, '0);
        add_row(mk_event(8'h3C, 60, 90, 0, 0, 0, 6005, 0), ROW_NONE, '0);
    endtask

    task automatic report_error(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_error($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    task automatic send_event(input t_event ev, input t_row_mode mode, input t_note_rec want);
        bit        has_rec;
        t_note_rec pred;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ev;
        do begin
            @(posedge i_clk);
        end while (s_axis_tready !== 1'b1);
        pair_note_event(ev, has_rec, pred);
        if (mode == ROW_PREDICT && has_rec) begin
            pending_records = {pending_records, pred};
        end else if (mode == ROW_RECORD) begin
            pending_records = {pending_records, want};
        end
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_for_records();
        int guard;
        guard = 0;
        while (pending_records.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    initial begin : receiver
        int seg_left;
        int ready_pct;
        m_axis_tready = 1'b1;
        seg_left      = 0;
        ready_pct     = 100;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    case ($urandom_range(0, 3))
                        0: ready_pct = 100;
                        1: ready_pct = 80;
                        2: ready_pct = 50;
                        default: ready_pct = 15;
                    endcase
                    seg_left = $urandom_range(20, 80);
                end
                seg_left--;
                m_axis_tready <= ($urandom_range(0, 99) < ready_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_records
        t_note_rec want;
        t_record   got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_records.size() == 0) begin
                report_error("record with no pending item");
            end else begin
                want = pending_records.pop_front();
                compare_field("kind", 32'(m_axis_tuser), 32'(want.kind));
                compare_field("start_time", got.start_time, want.rec.start_time);
                compare_field("duration", got.duration, want.rec.duration);
                compare_field("number", 32'(got.number), 32'(want.rec.number));
                compare_field("amount", 32'(got.amount), 32'(want.rec.amount));
                compare_field("accidentals", 32'(got.accidentals),
                              32'(want.rec.accidentals));
                compare_field("channel", 32'(got.channel), 32'(want.rec.channel));
                compare_field("track", 32'(got.track), 32'(want.rec.track));
                compare_field("start_unknown", 32'(got.start_unknown),
                              32'(want.rec.start_unknown));
                compare_field("zero fill", 32'(got.pad), 32'(want.rec.pad));
            end
        end
    end

    initial begin : stimulus
        t_event ev;
        bit     ignorable;
        bit     hold_sent;
        bit     drain_sent;
        int     counted;
        int     burst_left;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        hold_request  = 1'b0;
        error_count   = 0;
        tick_now      = 32'($urandom);
        hold_sent     = 1'b0;
        drain_sent    = 1'b0;
        counted       = 0;
        burst_left    = 0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            key_seen[k] = 1'b0;
        end
        build_directed_rows();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_event(directed_rows[i].ev, directed_rows[i].mode, directed_rows[i].want);
            if ($urandom_range(0, 3) == 0) begin
                pause_sender($urandom_range(1, 3));
            end
        end
        pause_sender(1);
        wait_for_records();

        while (counted < ITEM_GOAL) begin
            if (counted == 200 && !hold_sent) begin
                hold_sent    = 1'b1;
                hold_request = 1'b1;
                burst_left   = 40;
            end
            if (counted == 400 && !drain_sent) begin
                drain_sent = 1'b1;
                pause_sender(1);
                wait_for_records();
            end
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0) begin
                    pause_sender($urandom_range(1, 6));
                end
                burst_left = $urandom_range(1, 24);
            end
            ev = next_random_event(ignorable);
            send_event(ev, ROW_PREDICT, '0);
            burst_left--;
            if (!ignorable) begin
                counted++;
            end
        end

        pause_sender(1);
        wait_for_records();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_records.size() != 0) begin
            report_error($sformatf("%0d records never arrived", pending_records.size()));
        end
        if (error_count == 0) begin
            $display("[midi_note_event_pairer_top] OK");
        end else begin
            $display("[midi_note_event_pairer_top] ERROR");
        end
        $finish;
    end

endmodule
